// ===== rtl/dww_pkg.sv =====
// Shared types, codes and calendar tables for the DST window and weekday core.
`timescale 1ns / 1ps
package dww_pkg;

  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned ZoneW  = 5;
  localparam int unsigned OffW   = 17;
  localparam int unsigned CfgW   = 5;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_DST_ENABLE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_START_MONTH = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_END_MONTH   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_ZONE_HOURS  = 2'd3;

  localparam logic [MonthW-1:0] RST_START_MONTH = 4'd3;
  localparam logic [MonthW-1:0] RST_END_MONTH   = 4'd10;

  // Reciprocal of 100 for 12-bit years: q = (y * 1311) >> 17
  localparam int unsigned RecipMul   = 1311;
  localparam int unsigned RecipShift = 17;
  localparam int unsigned ProdW      = 23;
  localparam int unsigned CentW      = 6;

  localparam int signed SecPerHour = 3600;

  // Packed in key order: comparing two of these compares the time of year.
  typedef struct packed {
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
  } dww_time_t;

  typedef struct packed {
    logic [2:0] base7;
    logic       leap;
  } dww_year_t;

  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [6:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = 7'(x[7:6]) + 7'(x[5:0]);
    s2 = 4'(s1[6:3]) + 4'(s1[2:0]);
    s3 = 4'(s2[3]) + 4'(s2[2:0]);
    return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
  endfunction

  function automatic logic [2:0] century_key(input logic [1:0] c);
    logic [2:0] k;
    case (c)
      2'd0:    k = 3'd6;
      2'd1:    k = 3'd4;
      2'd2:    k = 3'd2;
      default: k = 3'd0;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] month_key(input logic [MonthW-1:0] m);
    logic [2:0] k;
    case (m)
      4'd2, 4'd3, 4'd11: k = 3'd3;
      4'd4, 4'd7:        k = 3'd6;
      4'd5:              k = 3'd1;
      4'd6:              k = 3'd4;
      4'd8:              k = 3'd2;
      4'd9, 4'd12:       k = 3'd5;
      default:           k = 3'd0;
    endcase
    return k;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] n;
    case (m)
      4'd2:                    n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] weekday_of(input logic [2:0] base7, input logic leap,
                                            input logic [MonthW-1:0] m,
                                            input logic [DayW-1:0] d);
    logic [7:0] sum;
    logic       adj;
    adj = leap && (m == 4'd1 || m == 4'd2);
    sum = 8'(base7) + 8'(month_key(m)) + 8'(d) + (adj ? 8'd6 : 8'd0);
    return mod7(sum);
  endfunction

endpackage

// ===== rtl/dww_century.sv =====
// Stages 1-2: century split of the year, year key mod 7 and leap flag.
`timescale 1ns / 1ps
module dww_century
  import dww_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [YearW-1:0]  year_i,
  input  dww_time_t         time_i,
  output logic              valid_o,
  output dww_year_t         year_o,
  output dww_time_t         time_o
);

  logic             v1_q, v2_q;
  logic [YearW-1:0] y1_q;
  logic [CentW-1:0] cent1_q;
  dww_time_t        t1_q, t2_q;
  dww_year_t        yr2_q;

  logic [CentW-1:0] cent_d;
  logic [12:0]      hund;
  logic [6:0]       yy;
  logic [7:0]       base;
  dww_year_t        yr2_d;

  assign cent_d = CentW'(ProdW'(year_i) * ProdW'(RecipMul) >> RecipShift);

  always_comb begin
    hund = 13'(cent1_q) * 13'd100;
    yy   = 7'(13'(y1_q) - hund);
    base = 8'(century_key(cent1_q[1:0])) + 8'(yy) + 8'(yy[6:2]);
    yr2_d.base7 = mod7(base);
    yr2_d.leap  = ((y1_q[1:0] == 2'd0) && (yy != 7'd0)) ||
                  ((yy == 7'd0) && (cent1_q[1:0] == 2'd0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    y1_q    <= year_i;
    cent1_q <= cent_d;
    t1_q    <= time_i;
    yr2_q   <= yr2_d;
    t2_q    <= t1_q;
  end

  assign valid_o = v2_q;
  assign year_o  = yr2_q;
  assign time_o  = t2_q;

endmodule

// ===== rtl/dww_calendar.sv =====
// Stage 3: weekday of the date and last Sundays of the start and end months.
`timescale 1ns / 1ps
module dww_calendar
  import dww_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  dww_year_t         year_i,
  input  dww_time_t         time_i,
  input  logic [MonthW-1:0] start_month_i,
  input  logic [MonthW-1:0] end_month_i,
  output logic              valid_o,
  output logic [2:0]        weekday_o,
  output dww_time_t         time_o,
  output dww_time_t         lo_o,
  output dww_time_t         hi_o
);

  logic            v_q;
  logic [2:0]      wd_q;
  dww_time_t       t_q, lo_q, hi_q;

  logic [DayW-1:0] len_s, len_e;
  dww_time_t       lo_d, hi_d;

  always_comb begin
    len_s = month_len(start_month_i, year_i.leap);
    len_e = month_len(end_month_i, year_i.leap);
    lo_d.month  = start_month_i;
    lo_d.day    = len_s - DayW'(weekday_of(year_i.base7, year_i.leap, start_month_i, len_s));
    lo_d.hour   = HourW'(2);
    lo_d.minute = '0;
    lo_d.second = '0;
    hi_d.month  = end_month_i;
    hi_d.day    = len_e - DayW'(weekday_of(year_i.base7, year_i.leap, end_month_i, len_e));
    hi_d.hour   = HourW'(3);
    hi_d.minute = '0;
    hi_d.second = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    wd_q <= weekday_of(year_i.base7, year_i.leap, time_i.month, time_i.day);
    t_q  <= time_i;
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign valid_o   = v_q;
  assign weekday_o = wd_q;
  assign time_o    = t_q;
  assign lo_o      = lo_q;
  assign hi_o      = hi_q;

endmodule

// ===== rtl/dww_window.sv =====
// Stage 4: summer window compare and UTC offset, registered result.
`timescale 1ns / 1ps
module dww_window
  import dww_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [2:0]             weekday_i,
  input  dww_time_t              time_i,
  input  dww_time_t              lo_i,
  input  dww_time_t              hi_i,
  input  logic                   dst_enable_i,
  input  logic signed [ZoneW-1:0] zone_hours_i,
  output logic                   valid_o,
  output logic [2:0]             weekday_o,
  output logic                   in_summer_o,
  output logic signed [OffW-1:0] offset_seconds_o
);

  logic                   v_q;
  logic [2:0]             wd_q;
  logic                   sum_q;
  logic signed [OffW-1:0] off_q;

  logic                   summer;
  logic signed [5:0]      hours;
  logic signed [OffW-1:0] hours_x;
  logic signed [OffW-1:0] off_d;

  always_comb begin
    summer  = (time_i > lo_i) && (time_i < hi_i);
    hours   = 6'(zone_hours_i) + ((summer && dst_enable_i) ? 6'sd1 : 6'sd0);
    hours_x = OffW'(hours);
    off_d   = hours_x * OffW'(SecPerHour);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    wd_q  <= weekday_i;
    sum_q <= summer;
    off_q <= off_d;
  end

  assign valid_o          = v_q;
  assign weekday_o        = wd_q;
  assign in_summer_o      = sum_q;
  assign offset_seconds_o = off_q;

endmodule

// ===== rtl/dst_window_and_weekday_core.sv =====
// Top level: configuration registers and the four-stage date pipeline.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------------
//  command   | start_i / busy_o   | year_i month_i day_i hour_i minute_i second_i
//  result    | done_o (strobe)    | weekday_o in_summer_o offset_seconds_o
//  config    | cfg_we_i           | cfg_idx_i cfg_wdata_i
//
// One transaction enters per cycle; busy_o is never raised.
// The result strobes done_o after start_i, through the stages: yearly split (multiply by
// reciprocal of 100), year key mod 7, month tables and last Sundays, window compare.
// Reset clears valid bits and loads the register defaults; payload regs are not reset.
// The receiver cannot stall, so the pipeline always advances.
`timescale 1ns / 1ps
module dst_window_and_weekday_core
  import dww_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [YearW-1:0]       year_i,
  input  logic [MonthW-1:0]      month_i,
  input  logic [DayW-1:0]        day_i,
  input  logic [HourW-1:0]       hour_i,
  input  logic [MinW-1:0]        minute_i,
  input  logic [SecW-1:0]        second_i,
  output logic                   done_o,
  output logic [2:0]             weekday_o,
  output logic                   in_summer_o,
  output logic signed [OffW-1:0] offset_seconds_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgW-1:0]        cfg_wdata_i
);

  logic                    dst_enable_q;
  logic [MonthW-1:0]       start_month_q, end_month_q;
  logic signed [ZoneW-1:0] zone_hours_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_enable_q  <= 1'b0;
      start_month_q <= RST_START_MONTH;
      end_month_q   <= RST_END_MONTH;
      zone_hours_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DST_ENABLE:  dst_enable_q  <= cfg_wdata_i[0];
        REG_START_MONTH: start_month_q <= cfg_wdata_i[MonthW-1:0];
        REG_END_MONTH:   end_month_q   <= cfg_wdata_i[MonthW-1:0];
        REG_ZONE_HOURS:  zone_hours_q  <= cfg_wdata_i[ZoneW-1:0];
        default: ;
      endcase
    end
  end

  logic      accept;
  dww_time_t t_in;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign t_in.month  = month_i;
  assign t_in.day    = day_i;
  assign t_in.hour   = hour_i;
  assign t_in.minute = minute_i;
  assign t_in.second = second_i;

  logic      v2;
  dww_year_t yr2;
  dww_time_t t2;

  dww_century u_century (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .year_i  (year_i),
    .time_i  (t_in),
    .valid_o (v2),
    .year_o  (yr2),
    .time_o  (t2)
  );

  logic       v3;
  logic [2:0] wd3;
  dww_time_t  t3, lo3, hi3;

  dww_calendar u_calendar (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (v2),
    .year_i        (yr2),
    .time_i        (t2),
    .start_month_i (start_month_q),
    .end_month_i   (end_month_q),
    .valid_o       (v3),
    .weekday_o     (wd3),
    .time_o        (t3),
    .lo_o          (lo3),
    .hi_o          (hi3)
  );

  dww_window u_window (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (v3),
    .weekday_i        (wd3),
    .time_i           (t3),
    .lo_i             (lo3),
    .hi_i             (hi3),
    .dst_enable_i     (dst_enable_q),
    .zone_hours_i     (zone_hours_q),
    .valid_o          (done_o),
    .weekday_o        (weekday_o),
    .in_summer_o      (in_summer_o),
    .offset_seconds_o (offset_seconds_o)
  );

  logic signed [OffW-1:0] std_offset;
  assign std_offset = OffW'(zone_hours_q) * OffW'(SecPerHour);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_o)
    else $error("transaction did not complete after four cycles");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("result without a matching transaction");

  a_std_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !dst_enable_q && $stable(zone_hours_q) |-> offset_seconds_o == std_offset)
    else $error("standard offset mismatch with summer hour disabled");

  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> weekday_o != 3'd7)
    else $error("weekday out of range");

endmodule

// ===== tb/sv/dst_window_and_weekday_core_tb.sv =====
// Self-checking testbench for the DST window and weekday core.
`timescale 1ns / 1ps
module dst_window_and_weekday_core_tb;
  import dww_pkg::*;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
  } date_item_t;

  typedef struct packed {
    logic [2:0]     weekday;
    logic           in_summer;
    logic [OffW-1:0] offset;
  } clock_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [YearW-1:0]       year_i;
  logic [MonthW-1:0]      month_i;
  logic [DayW-1:0]        day_i;
  logic [HourW-1:0]       hour_i;
  logic [MinW-1:0]        minute_i;
  logic [SecW-1:0]        second_i;
  logic                   done_o;
  logic [2:0]             weekday_o;
  logic                   in_summer_o;
  logic signed [OffW-1:0] offset_seconds_o;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_idx_i;
  logic [CfgW-1:0]        cfg_wdata_i;

  // Register mirror, reset values
  logic              dst_on      = 1'b0;
  logic [MonthW-1:0] summer_from = RST_START_MONTH;
  logic [MonthW-1:0] summer_to   = RST_END_MONTH;
  logic [ZoneW-1:0]  zone_cfg    = '0;

  clock_result_t pending_results[$];
  int unsigned   err_count     = 0;
  int unsigned   dates_sent    = 0;
  int unsigned   results_seen  = 0;
  int unsigned   summer_seen   = 0;
  int unsigned   config_writes = 0;

  dst_window_and_weekday_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .year_i           (year_i),
    .month_i          (month_i),
    .day_i            (day_i),
    .hour_i           (hour_i),
    .minute_i         (minute_i),
    .second_i         (second_i),
    .done_o           (done_o),
    .weekday_o        (weekday_o),
    .in_summer_o      (in_summer_o),
    .offset_seconds_o (offset_seconds_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("Some tests failed");
    $finish;
  end

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= 40) $display("ERROR %0t: %s", $time, msg);
  endtask

  // ---------------- calendar predictor ----------------
  function automatic bit is_leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned century_code(input int unsigned c);
    case (c % 4)
      0:       return 6;
      1:       return 4;
      2:       return 2;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned key_of_month(input int unsigned m);
    case (m)
      2, 3, 11: return 3;
      4, 7:     return 6;
      5:        return 1;
      6:        return 4;
      8:        return 2;
      9, 12:    return 5;
      default:  return 0;
    endcase
  endfunction

  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    case (m)
      2:             return is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic int unsigned day_of_week(input int unsigned y, input int unsigned m,
                                              input int unsigned d);
    int unsigned yy;
    int unsigned sum;
    yy  = y % 100;
    sum = century_code(y / 100) + yy + yy / 4 + key_of_month(m) + d;
    if (is_leap_year(y) && (m == 1 || m == 2)) sum += 6;
    return sum % 7;
  endfunction

  function automatic int unsigned last_sunday_of(input int unsigned y, input int unsigned m);
    int unsigned len;
    len = days_in_month(y, m);
    return len - day_of_week(y, m, len);
  endfunction

  function automatic int unsigned year_stamp(input int unsigned m, input int unsigned d,
                                             input int unsigned h, input int unsigned mi,
                                             input int unsigned s);
    return (m << 24) | (d << 18) | (h << 12) | (mi << 6) | s;
  endfunction

  function automatic clock_result_t predict_clock(input date_item_t it);
    clock_result_t r;
    int unsigned   now_key;
    int unsigned   begin_key;
    int unsigned   end_key;
    int            hours;
    bit            summer;
    now_key   = year_stamp(it.month, it.day, it.hour, it.minute, it.second);
    begin_key = year_stamp(summer_from, last_sunday_of(it.year, summer_from), 2, 0, 0);
    end_key   = year_stamp(summer_to, last_sunday_of(it.year, summer_to), 3, 0, 0);
    summer    = (now_key > begin_key) && (now_key < end_key);
    hours     = $signed(zone_cfg);
    if (summer && dst_on) hours += 1;
    r.weekday   = 3'(day_of_week(it.year, it.month, it.day));
    r.in_summer = summer;
    r.offset    = OffW'(hours * SecPerHour);
    return r;
  endfunction

  // ---------------- driving ----------------
  function automatic date_item_t mk_date(input int unsigned y, input int unsigned m,
                                         input int unsigned d, input int unsigned h,
                                         input int unsigned mi, input int unsigned s);
    date_item_t it;
    it.year   = YearW'(y);
    it.month  = MonthW'(m);
    it.day    = DayW'(d);
    it.hour   = HourW'(h);
    it.minute = MinW'(mi);
    it.second = SecW'(s);
    return it;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_date(input date_item_t it, input int unsigned gap);
    start_i  <= 1'b1;
    year_i   <= it.year;
    month_i  <= it.month;
    day_i    <= it.day;
    hour_i   <= it.hour;
    minute_i <= it.minute;
    second_i <= it.second;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_results.push_back(predict_clock(it));
    dates_sent++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    if (start_i) start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 && waited < 200) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report_error($sformatf("%0d results never arrived", pending_results.size()));
      pending_results.delete();
    end
  endtask

  // Writes all four registers; only called with the pipeline empty.
  task automatic set_config(input logic [CfgW-1:0] en_w, input logic [CfgW-1:0] from_w,
                            input logic [CfgW-1:0] to_w, input logic [CfgW-1:0] zone_w);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_DST_ENABLE;
    cfg_wdata_i <= en_w;
    @(posedge clk_i);
    dst_on      = en_w[0];
    cfg_idx_i   <= REG_START_MONTH;
    cfg_wdata_i <= from_w;
    @(posedge clk_i);
    summer_from = from_w[MonthW-1:0];
    cfg_idx_i   <= REG_END_MONTH;
    cfg_wdata_i <= to_w;
    @(posedge clk_i);
    summer_to   = to_w[MonthW-1:0];
    cfg_idx_i   <= REG_ZONE_HOURS;
    cfg_wdata_i <= zone_w;
    @(posedge clk_i);
    zone_cfg    = zone_w[ZoneW-1:0];
    cfg_we_i    <= 1'b0;
    config_writes++;
  endtask

  function automatic date_item_t random_date();
    date_item_t  it;
    int unsigned r;
    int unsigned y;
    int unsigned m;
    int unsigned sel;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      it = date_item_t'($urandom);
      it.year = YearW'($urandom);
    end else if (r < 50) begin
      // Around the window edges of the current setting
      y   = $urandom_range(1700, 2299);
      m   = $urandom_range(0, 1) ? summer_from : summer_to;
      sel = $urandom_range(0, 3);
      it  = mk_date(y, m, last_sunday_of(y, m) + $urandom_range(0, 2) - 1,
                    $urandom_range(1, 4),
                    sel == 0 ? 0 : (sel == 1 ? 59 : $urandom_range(0, 59)),
                    sel == 0 ? 0 : (sel == 1 ? 59 : $urandom_range(0, 59)));
    end else begin
      y  = $urandom_range(1700, 2299);
      m  = $urandom_range(1, 12);
      it = mk_date(y, m, $urandom_range(1, days_in_month(y, m)), $urandom_range(0, 23),
                   $urandom_range(0, 59), $urandom_range(0, 59));
    end
    return it;
  endfunction

  // ---------------- result check ----------------
  always @(posedge clk_i) begin : check_results
    clock_result_t exp_r;
    if (rst_ni && done_o) begin
      results_seen++;
      if (in_summer_o) summer_seen++;
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected transaction: weekday %0d summer %0b offset %0d",
                               weekday_o, in_summer_o, offset_seconds_o));
      end else begin
        exp_r = pending_results.pop_front();
        if (weekday_o !== exp_r.weekday)
          report_error($sformatf("weekday %0d, expected %0d", weekday_o, exp_r.weekday));
        if (in_summer_o !== exp_r.in_summer)
          report_error($sformatf("in_summer %0b, expected %0b", in_summer_o, exp_r.in_summer));
        if (offset_seconds_o !== exp_r.offset)
          report_error($sformatf("offset %0d, expected %0d", offset_seconds_o,
                                 $signed(exp_r.offset)));
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_calendar_extremes();
    send_date(mk_date(0, 0, 0, 0, 0, 0), pick_gap());
    send_date(mk_date(4095, 15, 31, 31, 63, 63), pick_gap());
    send_date(mk_date(1700, 1, 1, 0, 0, 0), pick_gap());
    send_date(mk_date(2299, 12, 31, 23, 59, 59), pick_gap());
    send_date(mk_date(2000, 2, 29, 12, 30, 30), pick_gap());
    send_date(mk_date(1900, 2, 28, 0, 0, 0), pick_gap());
    send_date(mk_date(1900, 3, 1, 0, 0, 0), pick_gap());
    send_date(mk_date(2024, 1, 1, 0, 0, 0), pick_gap());
    send_date(mk_date(2023, 13, 5, 7, 7, 7), pick_gap());
    send_date(mk_date(2100, 2, 0, 1, 1, 1), pick_gap());
    drain_results();
  endtask

  task automatic test_window_edges();
    int unsigned ls;
    int unsigned le;
    set_config(5'd1, 5'd3, 5'd10, 5'd1);
    ls = last_sunday_of(2024, 3);
    le = last_sunday_of(2024, 10);
    send_date(mk_date(2024, 3, ls, 2, 0, 0), pick_gap());
    send_date(mk_date(2024, 3, ls, 2, 0, 1), pick_gap());
    send_date(mk_date(2024, 3, ls, 1, 59, 59), pick_gap());
    send_date(mk_date(2024, 10, le, 2, 59, 59), pick_gap());
    send_date(mk_date(2024, 10, le, 3, 0, 0), pick_gap());
    send_date(mk_date(2024, 7, 4, 31, 63, 63), pick_gap());
    send_date(mk_date(2024, 3, ls, 31, 63, 63), pick_gap());
    drain_results();
  endtask

  task automatic test_inverted_window();
    set_config(5'h1F, 5'd10, 5'd3, 5'h10);
    send_date(mk_date(2021, 6, 15, 12, 0, 0), pick_gap());
    send_date(mk_date(2021, 1, 1, 0, 0, 0), pick_gap());
    send_date(mk_date(2021, 3, 31, 4, 0, 0), pick_gap());
    drain_results();
  endtask

  task automatic test_random_settings();
    bit burst;
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0:       set_config(5'd1, 5'd3, 5'd10, 5'd0);
        1:       set_config(5'd1, 5'd1, 5'd12, 5'h10);
        2:       set_config(5'd1, 5'd12, 5'd1, 5'd15);
        3:       set_config(5'd0, 5'd3, 5'd10, 5'(-12));
        4:       set_config(5'd1, 5'd4, 5'd9, 5'd14);
        5:       set_config(5'd1, 5'd0, 5'd15, 5'($urandom));
        6:       set_config(5'h1E, 5'd2, 5'd2, 5'($urandom));
        default: set_config(5'($urandom), {1'($urandom), 4'($urandom_range(1, 12))},
                            {1'($urandom), 4'($urandom_range(1, 12))}, 5'($urandom));
      endcase
      burst = ($urandom_range(0, 3) == 0);
      repeat (125) send_date(random_date(), burst ? 0 : pick_gap());
      drain_results();
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    year_i      <= '0;
    month_i     <= '0;
    day_i       <= '0;
    hour_i      <= '0;
    minute_i    <= '0;
    second_i    <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_calendar_extremes();
    test_window_edges();
    test_inverted_window();
    test_random_settings();

    repeat (10) @(posedge clk_i);
    $display("Sent %0d dates under %0d register settings, checked %0d results.",
             dates_sent, config_writes + 1, results_seen);
    $display("%0d results fell inside the summer window; %0d mismatches.",
             summer_seen, err_count);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
